// ===== rtl/core/art_pkg.sv =====
// Shared types and codes for the address range table.
package art_pkg;

  localparam int ADDR_W = 64;

  localparam logic [1:0] KIND_INSERT = 2'd0;
  localparam logic [1:0] KIND_REMOVE = 2'd1;
  localparam logic [1:0] KIND_FIND   = 2'd2;
  localparam logic [1:0] KIND_CLEAR  = 2'd3;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic              vld;
    logic [ADDR_W-1:0] lo;
    logic [ADDR_W-1:0] hi;
  } ent_t;

endpackage

// ===== rtl/core/art_mem.sv =====
// Entry store: one write port, one registered read port.
module art_mem #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  art_pkg::ent_t    wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output art_pkg::ent_t    rdata
);
  import art_pkg::*;

  ent_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/art_cmp.sv =====
// Shared overlap compare between one stored entry and the request range.
module art_cmp (
  input  art_pkg::ent_t                  ent,
  input  logic [art_pkg::ADDR_W-1:0]     lo,
  input  logic [art_pkg::ADDR_W-1:0]     hi,
  output logic                           hit,
  output logic                           free
);
  import art_pkg::*;

  assign hit  = ent.vld && !(ent.hi < lo) && !(ent.lo > hi);
  assign free = !ent.vld;

endmodule

// ===== rtl/core/address_range_table.sv =====
// Address range table: entry scan sequencer, shared compare and entry store.
// Insert, remove and find scan every slot one per cycle through the single
// read port; a write state then stores any change and registers the result.
// Clear sweeps the store one slot per cycle. One request at a time.
// After reset the store is swept invalid; in_stall is high meanwhile.
module address_range_table #(
  parameter int ENTRIES = 64
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [1:0]                   kind,
  input  logic [art_pkg::ADDR_W-1:0]   start_addr,
  input  logic [art_pkg::ADDR_W-1:0]   end_addr,
  input  logic [art_pkg::ADDR_W-1:0]   addr,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [1:0]                   status,
  output logic [art_pkg::ADDR_W-1:0]   found_start,
  output logic [art_pkg::ADDR_W-1:0]   found_end
);
  import art_pkg::*;

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW    = IDX_W + 1;
  localparam logic [CW-1:0] CNT_END  = CW'(ENTRIES);
  localparam logic [CW-1:0] CNT_LAST = CW'(ENTRIES - 1);

  typedef enum logic [4:0] {
    S_WIPE  = 5'b00001,
    S_IDLE  = 5'b00010,
    S_SCAN  = 5'b00100,
    S_WRITE = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t             state;
  logic [CW-1:0]      cnt;
  logic               wipe_reply;
  logic [1:0]         req_kind;
  logic [ADDR_W-1:0]  req_lo;
  logic [ADDR_W-1:0]  req_hi;
  logic               rd_pend;
  logic [IDX_W-1:0]   rd_idx;
  logic               hit_found;
  logic [IDX_W-1:0]   hit_idx;
  logic [ADDR_W-1:0]  hit_lo;
  logic [ADDR_W-1:0]  hit_hi;
  logic               free_found;
  logic [IDX_W-1:0]   free_idx;
  logic [1:0]         res_status;
  logic [ADDR_W-1:0]  res_lo;
  logic [ADDR_W-1:0]  res_hi;

  logic               mem_we;
  logic [IDX_W-1:0]   mem_waddr;
  ent_t               mem_wdata;
  logic               mem_re;
  ent_t               mem_rdata;
  logic               cmp_hit;
  logic               cmp_free;
  logic               accept;
  logic               out_free;
  logic [1:0]         wr_status;
  logic [ADDR_W-1:0]  wr_lo;
  logic [ADDR_W-1:0]  wr_hi;

  art_mem #(
    .DEPTH (ENTRIES),
    .AW    (IDX_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (cnt[IDX_W-1:0]),
    .rdata (mem_rdata)
  );

  art_cmp u_cmp (
    .ent  (mem_rdata),
    .lo   (req_lo),
    .hi   (req_hi),
    .hit  (cmp_hit),
    .free (cmp_free)
  );

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign mem_re   = (state == S_SCAN) && (cnt != CNT_END);

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cnt[IDX_W-1:0];
    mem_wdata = '0;
    wr_status = ST_OK;
    wr_lo     = '0;
    wr_hi     = '0;
    case (req_kind)
      KIND_INSERT: begin
        if (hit_found) begin
          wr_status = ST_MISS;
        end else if (!free_found) begin
          wr_status = ST_FULL;
        end
      end
      KIND_REMOVE, KIND_FIND: begin
        if (!hit_found) begin
          wr_status = ST_MISS;
        end else if (req_kind == KIND_FIND) begin
          wr_lo = hit_lo;
          wr_hi = hit_hi;
        end
      end
      default: begin
        wr_status = ST_OK;
      end
    endcase
    case (state)
      S_WIPE: begin
        mem_we = 1'b1;
      end
      S_WRITE: begin
        if (req_kind == KIND_INSERT && !hit_found && free_found) begin
          mem_we    = 1'b1;
          mem_waddr = free_idx;
          mem_wdata = '{vld: 1'b1, lo: req_lo, hi: req_hi};
        end else if (req_kind == KIND_REMOVE && hit_found) begin
          mem_we    = 1'b1;
          mem_waddr = hit_idx;
        end
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_WIPE;
      cnt        <= '0;
      wipe_reply <= 1'b0;
      rd_pend    <= 1'b0;
      hit_found  <= 1'b0;
      free_found <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (out_valid && !out_stall && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_WIPE: begin
          cnt <= cnt + 1'b1;
          if (cnt == CNT_LAST) begin
            res_status <= ST_OK;
            res_lo     <= '0;
            res_hi     <= '0;
            state      <= wipe_reply ? S_DONE : S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            req_kind   <= kind;
            req_lo     <= (kind == KIND_INSERT) ? start_addr : addr;
            req_hi     <= (kind == KIND_INSERT) ? end_addr : addr;
            cnt        <= '0;
            rd_pend    <= 1'b0;
            hit_found  <= 1'b0;
            free_found <= 1'b0;
            wipe_reply <= 1'b1;
            state      <= (kind == KIND_CLEAR) ? S_WIPE : S_SCAN;
          end
        end
        S_SCAN: begin
          rd_pend <= mem_re;
          rd_idx  <= cnt[IDX_W-1:0];
          if (mem_re) begin
            cnt <= cnt + 1'b1;
          end
          if (rd_pend) begin
            if (cmp_hit && !hit_found) begin
              hit_found <= 1'b1;
              hit_idx   <= rd_idx;
              hit_lo    <= mem_rdata.lo;
              hit_hi    <= mem_rdata.hi;
            end
            if (cmp_free && !free_found) begin
              free_found <= 1'b1;
              free_idx   <= rd_idx;
            end
          end
          if (!mem_re && !rd_pend) begin
            state <= S_WRITE;
          end
        end
        S_WRITE: begin
          res_status <= wr_status;
          res_lo     <= wr_lo;
          res_hi     <= wr_hi;
          state      <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            out_valid   <= 1'b1;
            status      <= res_status;
            found_start <= res_lo;
            found_end   <= res_hi;
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for address_range_table: shadow range table, scoreboard, drivers.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import art_pkg::*;

  localparam int SLOTS = 64;
  localparam int ITEMS = 2000;
  localparam int BLOCK = 250;
  localparam int STALL_LIMIT = 3000;
  localparam int LONG_HOLD = 400;
  localparam logic [ADDR_W-1:0] ADDR_MAX = '1;

  typedef struct packed {
    logic [1:0]        status;
    logic [ADDR_W-1:0] lo;
    logic [ADDR_W-1:0] hi;
  } lookup_result_t;

  class range_shadow;
    bit                live[SLOTS];
    logic [ADDR_W-1:0] slot_lo[SLOTS];
    logic [ADDR_W-1:0] slot_hi[SLOTS];
    lookup_result_t    awaited[$];
    int                errors;
    int                kinds_seen[4];
    int                status_seen[3];

    function int first_overlap(logic [ADDR_W-1:0] lo, logic [ADDR_W-1:0] hi);
      for (int i = 0; i < SLOTS; i++)
        if (live[i] && !(slot_hi[i] < lo) && !(slot_lo[i] > hi)) return i;
      return -1;
    endfunction

    function void note_request(logic [1:0] k, logic [ADDR_W-1:0] s,
                               logic [ADDR_W-1:0] e, logic [ADDR_W-1:0] a);
      lookup_result_t res;
      int slot;
      res = '{status: ST_OK, lo: '0, hi: '0};
      slot = -1;
      case (k)
        KIND_INSERT: begin
          if (first_overlap(s, e) >= 0) begin
            res.status = ST_MISS;
          end else begin
            for (int i = 0; i < SLOTS; i++)
              if (!live[i]) begin
                slot = i;
                break;
              end
            if (slot < 0) begin
              res.status = ST_FULL;
            end else begin
              live[slot] = 1'b1;
              slot_lo[slot] = s;
              slot_hi[slot] = e;
            end
          end
        end
        KIND_REMOVE: begin
          slot = first_overlap(a, a);
          if (slot < 0) res.status = ST_MISS;
          else live[slot] = 1'b0;
        end
        KIND_FIND: begin
          slot = first_overlap(a, a);
          if (slot < 0) begin
            res.status = ST_MISS;
          end else begin
            res.lo = slot_lo[slot];
            res.hi = slot_hi[slot];
          end
        end
        default: begin
          foreach (live[i]) live[i] = 1'b0;
        end
      endcase
      kinds_seen[k]++;
      status_seen[res.status]++;
      awaited.push_back(res);
    endfunction

    function void check_result(logic [1:0] st, logic [ADDR_W-1:0] fs,
                               logic [ADDR_W-1:0] fe);
      lookup_result_t want;
      if (awaited.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("ERROR: result with nothing outstanding: status %0d start %h end %h",
                   st, fs, fe);
        return;
      end
      want = awaited.pop_front();
      if (st !== want.status || fs !== want.lo || fe !== want.hi) begin
        errors++;
        if (errors <= 10)
          $display("ERROR: status %0d/%0d start %h/%h end %h/%h (expected/actual)",
                   want.status, st, want.lo, fs, want.hi, fe);
      end
    endfunction

    // Live slot with ordered bounds, so an address inside it exists.
    function bit pick_live(output int idx);
      int cand[$];
      for (int i = 0; i < SLOTS; i++)
        if (live[i] && slot_lo[i] <= slot_hi[i]) cand.push_back(i);
      if (cand.size() == 0) begin
        idx = -1;
        return 1'b0;
      end
      idx = cand[$urandom_range(0, cand.size() - 1)];
      return 1'b1;
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [1:0]        kind = KIND_CLEAR;
  logic [ADDR_W-1:0] start_addr = '0;
  logic [ADDR_W-1:0] end_addr = '0;
  logic [ADDR_W-1:0] addr = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [1:0]        status;
  logic [ADDR_W-1:0] found_start;
  logic [ADDR_W-1:0] found_end;

  range_shadow sb = new;
  bit quiet = 1'b0;
  bit long_hold = 1'b0;
  int idle_cycles = 0;

  address_range_table #(.ENTRIES(SLOTS)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .kind(kind), .start_addr(start_addr), .end_addr(end_addr), .addr(addr),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .found_start(found_start), .found_end(found_end)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic [ADDR_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [ADDR_W-1:0] point_in(int idx);
    logic [ADDR_W-1:0] span;
    int r;
    span = sb.slot_hi[idx] - sb.slot_lo[idx];
    r = $urandom_range(0, 99);
    if (r < 20) return sb.slot_lo[idx];
    if (r < 40) return sb.slot_hi[idx];
    if (r < 50) return sb.slot_lo[idx] - 1;
    if (r < 60) return sb.slot_hi[idx] + 1;
    if (span == ADDR_MAX) return rand64();
    return sb.slot_lo[idx] + rand64() % (span + 1);
  endfunction

  task automatic send_request(input logic [1:0] k, input logic [ADDR_W-1:0] s,
                              input logic [ADDR_W-1:0] e, input logic [ADDR_W-1:0] a);
    int gap;
    in_valid <= 1'b1;
    kind <= k;
    start_addr <= s;
    end_addr <= e;
    addr <= a;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(k, s, e, a);
    if (!quiet && $urandom_range(0, 6) == 0) begin
      gap = $urandom_range(1, 5);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (sb.awaited.size() != 0) @(posedge clk);
  endtask

  task automatic random_request(input bit filling);
    logic [1:0]        k;
    logic [ADDR_W-1:0] s, e, a;
    int                r, idx;
    r = $urandom_range(0, 99);
    if (filling)
      k = (r < 75) ? KIND_INSERT : (r < 95) ? KIND_FIND : KIND_REMOVE;
    else
      k = (r < 35) ? KIND_INSERT : (r < 60) ? KIND_REMOVE : (r < 97) ? KIND_FIND : KIND_CLEAR;
    s = rand64();
    a = rand64();
    if (k == KIND_INSERT && $urandom_range(0, 99) < 25 && sb.pick_live(idx))
      s = point_in(idx);
    r = $urandom_range(0, 99);
    if (r < 60) e = s + $urandom_range(0, 255);
    else if (r < 85) e = s + {32'h0, $urandom};
    else if (r < 93) e = s - $urandom_range(1, 255);
    else e = rand64();
    if ((k == KIND_FIND || k == KIND_REMOVE) && $urandom_range(0, 99) < 75
        && sb.pick_live(idx))
      a = point_in(idx);
    send_request(k, s, e, a);
  endtask

  // Receiver: random stall bursts, plus one long hold-off on request.
  initial begin
    int n;
    forever begin
      @(posedge clk);
      if (long_hold) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        long_hold = 1'b0;
        out_stall <= 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        n = $urandom_range(1, 5);
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk)
    if (!rst && out_valid && !out_stall)
      sb.check_result(status, found_start, found_end);

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("timeout: no transfer for %0d cycles, %0d results outstanding",
               STALL_LIMIT, sb.awaited.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    send_request(KIND_CLEAR,  rand64(), rand64(), rand64());
    send_request(KIND_FIND,   rand64(), rand64(), '0);
    send_request(KIND_INSERT, '0, '0, rand64());
    send_request(KIND_INSERT, ADDR_MAX, ADDR_MAX, rand64());
    send_request(KIND_FIND,   rand64(), rand64(), '0);
    send_request(KIND_FIND,   rand64(), rand64(), ADDR_MAX);
    send_request(KIND_FIND,   rand64(), rand64(), 64'h1);
    // reversed bounds: stored, contains nothing, still blocks overlapping inserts
    send_request(KIND_INSERT, 64'h1000, 64'h10, rand64());
    send_request(KIND_FIND,   rand64(), rand64(), 64'h800);
    send_request(KIND_INSERT, 64'h20, 64'h30, rand64());
    send_request(KIND_INSERT, 64'h8, 64'h2000, rand64());
    send_request(KIND_INSERT, 64'h31, ADDR_MAX - 1, rand64());
    send_request(KIND_FIND,   rand64(), rand64(), 64'h8000_0000_0000_0000);
    send_request(KIND_FIND,   rand64(), rand64(), 64'h30);
    send_request(KIND_REMOVE, rand64(), rand64(), 64'h25);
    send_request(KIND_REMOVE, rand64(), rand64(), 64'h25);
    send_request(KIND_INSERT, 64'h1, 64'h1f, rand64());
    send_request(KIND_REMOVE, rand64(), rand64(), ADDR_MAX);
    send_request(KIND_FIND,   rand64(), rand64(), ADDR_MAX);
    send_request(KIND_INSERT, ADDR_MAX, ADDR_MAX, rand64());
    send_request(KIND_CLEAR,  rand64(), rand64(), rand64());
    send_request(KIND_FIND,   rand64(), rand64(), '0);
    send_request(KIND_REMOVE, rand64(), rand64(), '0);
    send_request(KIND_INSERT, ADDR_MAX, '0, rand64());
    send_request(KIND_INSERT, 64'h5, 64'h5, rand64());
    drain_results();

    for (int i = 0; i < ITEMS; i++) begin
      if (i == 600) long_hold = 1'b1;
      if (i == 1200) drain_results();
      if (i == ITEMS - 300) quiet = 1'b1;
      random_request((i / BLOCK) % 2 == 0);
    end

    drain_results();
    repeat (SLOTS + 20) @(posedge clk);
    $display("covered: insert %0d, remove %0d, find %0d, clear %0d transfers",
             sb.kinds_seen[KIND_INSERT], sb.kinds_seen[KIND_REMOVE],
             sb.kinds_seen[KIND_FIND], sb.kinds_seen[KIND_CLEAR]);
    $display("outcomes: ok %0d, overlap/miss %0d, full %0d; mismatches %0d",
             sb.status_seen[ST_OK], sb.status_seen[ST_MISS], sb.status_seen[ST_FULL],
             sb.errors);
    if (sb.errors == 0 && sb.awaited.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
